// ----- hw/rtl/tehs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event heap scheduler package
// Shared constants, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package tehs_pkg;

   localparam int QUEUE_DEPTH_DEF = 2048;
   localparam int ID_BITS_DEF     = 16;

   localparam int CMD_W    = 3;
   localparam int VARID_W  = 16;
   localparam int TIME_W   = 64;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 12;

   typedef enum logic [CMD_W-1:0] {
      CMD_SCHEDULE   = 3'd0,
      CMD_UNSCHEDULE = 3'd1,
      CMD_SET_NOW    = 3'd2,
      CMD_POP_DUE    = 3'd3,
      CMD_CLEAR      = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_TIME  = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_READY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND_RD,
      S_FIND_CK,
      S_LAST_RD,
      S_LAST_CK,
      S_POP_RD,
      S_POP_CK,
      S_REF_RD,
      S_REF_CK,
      S_UP_RD,
      S_UP_CK,
      S_DN_RD,
      S_DN_LCK,
      S_DN_RCK,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/timed_event_heap_scheduler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timed event heap scheduler
// A binary min-heap of pending events ordered by due time, kept in one
// memory, with the current model time held beside it.
//
// Each request on the req_ channel carries a command, a variable id, a time
// and a payload; each produces exactly one response on the rsp_ channel.
// Set_now, clear, a pop_due with nothing due and a schedule in the past go
// straight to the done state. Schedule and unschedule search the heap
// linearly, reading and checking each pending entry, then walk the heap a
// level at a time: up by reading and checking the parent, down by reading
// the left child, checking it while reading the right, then checking the
// right. Pop_due reads the head and the last slot, then walks down. The
// memory's single read port sets these steps; one request runs at a time.
// Reset empties the heap and sets the model time to zero at once, with no
// clearing pass. A finished response waits in an output register while
// the next request is accepted; the block then stalls at its end until the
// receiver takes the waiting response.
// ----------------------------------------------------------------------------
module timed_event_heap_scheduler_top
   import tehs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int ID_BITS     = ID_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [VARID_W-1:0]  req_var_id,
   input  wire logic [TIME_W-1:0]   req_time_value,
   input  wire logic [VALUE_W-1:0]  req_payload,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_popped,
   output logic [VARID_W-1:0]       rsp_popped_id,
   output logic [VALUE_W-1:0]       rsp_popped_value,
   output logic [TIME_W-1:0]        rsp_next_time,
   output logic [COUNT_W-1:0]       rsp_pending_count,
   output logic [TIME_W-1:0]        rsp_model_time
);

   localparam int SLOT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_W  = ID_BITS + TIME_W + VALUE_W;
   localparam logic [SLOT_W:0] DEPTH_W = (SLOT_W + 1)'(QUEUE_DEPTH);
   localparam logic [SLOT_W-1:0] ROOT  = SLOT_W'(1);

   state_type             state_ff, state_in;
   logic [SLOT_W-1:0]     count_ff, count_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [TIME_W-1:0]     head_ff;
   cmd_type               cmd_ff, cmd_in;
   logic [ID_BITS-1:0]    eid_ff, eid_in;
   logic [TIME_W-1:0]     etime_ff, etime_in;
   logic [VALUE_W-1:0]    eval_ff, eval_in;
   logic [SLOT_W-1:0]     hole_ff, hole_in;
   logic [SLOT_W:0]       idx_ff, idx_in;
   logic [SLOT_W-1:0]     last_ff, last_in;
   logic [ENT_W-1:0]      lent_ff, lent_in;
   logic [SLOT_W-1:0]     lidx_ff, lidx_in;
   status_type            st_ff, st_in;
   logic                  pop_ff, pop_in;
   logic [ID_BITS-1:0]    pid_ff, pid_in;
   logic [VALUE_W-1:0]    pval_ff, pval_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  load;

   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr, rd_addr;
   logic [ENT_W-1:0]      wr_data, rd_data;
   logic [ID_BITS-1:0]    rd_id;
   logic [TIME_W-1:0]     rd_time;
   logic [TIME_W-1:0]     l_time;

   logic [ID_BITS+VARID_W-1:0] id_wide;
   logic [ID_BITS+VARID_W-1:0] pid_wide;
   logic [SLOT_W+COUNT_W-1:0]  cnt_wide;
   logic [SLOT_W:0]            child;
   logic [SLOT_W:0]            child_r;
   logic [ENT_W-1:0]           ent_e;

   logic [STATUS_W-1:0]   o_status_ff;
   logic                  o_popped_ff;
   logic [VARID_W-1:0]    o_pid_ff;
   logic [VALUE_W-1:0]    o_pval_ff;
   logic [TIME_W-1:0]     o_next_ff;
   logic [COUNT_W-1:0]    o_count_ff;
   logic [TIME_W-1:0]     o_now_ff;

   assign id_wide  = {{ID_BITS{1'b0}}, req_var_id};
   assign pid_wide = {{VARID_W{1'b0}}, pid_ff};
   assign cnt_wide = {{COUNT_W{1'b0}}, count_ff};
   assign child    = {hole_ff, 1'b0};
   assign child_r  = child + (SLOT_W + 1)'(1);
   assign ent_e    = {eid_ff, etime_ff, eval_ff};
   assign rd_id    = rd_data[ENT_W-1 -: ID_BITS];
   assign rd_time  = rd_data[VALUE_W +: TIME_W];
   assign l_time   = lent_ff[VALUE_W +: TIME_W];

   tehs_heap_ram #(
      .DEPTH  (QUEUE_DEPTH + 1),
      .ADDR_W (SLOT_W),
      .DATA_W (ENT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      eid_ff   <= eid_in;
      etime_ff <= etime_in;
      eval_ff  <= eval_in;
      hole_ff  <= hole_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      lent_ff  <= lent_in;
      lidx_ff  <= lidx_in;
      st_ff    <= st_in;
      pop_ff   <= pop_in;
      pid_ff   <= pid_in;
      pval_ff  <= pval_in;
      if (wr_en && wr_addr == ROOT) begin
         head_ff <= wr_data[VALUE_W +: TIME_W];
      end
      if (load) begin
         o_status_ff <= st_ff;
         o_popped_ff <= pop_ff;
         o_pid_ff    <= pid_wide[VARID_W-1:0];
         o_pval_ff   <= pval_ff;
         o_next_ff   <= (count_ff != '0) ? head_ff : '1;
         o_count_ff  <= cnt_wide[COUNT_W-1:0];
         o_now_ff    <= now_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      now_in       = now_ff;
      cmd_in       = cmd_ff;
      eid_in       = eid_ff;
      etime_in     = etime_ff;
      eval_in      = eval_ff;
      hole_in      = hole_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      lent_in      = lent_ff;
      lidx_in      = lidx_ff;
      st_in        = st_ff;
      pop_in       = pop_ff;
      pid_in       = pid_ff;
      pval_in      = pval_ff;
      wr_en        = 1'b0;
      wr_addr      = hole_ff;
      wr_data      = ent_e;
      rd_addr      = '0;
      load         = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_in   = cmd_type'(req_command);
               eid_in   = id_wide[ID_BITS-1:0];
               etime_in = req_time_value;
               eval_in  = req_payload;
               st_in    = ST_OK;
               pop_in   = 1'b0;
               pid_in   = '0;
               pval_in  = '0;
               idx_in   = (SLOT_W + 1)'(1);
               state_in = S_DONE;
               case (cmd_type'(req_command))
                  CMD_SCHEDULE: begin
                     if (req_time_value < now_ff) begin
                        st_in = ST_BAD_TIME;
                     end else begin
                        state_in = S_FIND_RD;
                     end
                  end
                  CMD_UNSCHEDULE: begin
                     state_in = S_FIND_RD;
                  end
                  CMD_SET_NOW: begin
                     if (req_time_value <= now_ff) begin
                        st_in = ST_BAD_TIME;
                     end else if (count_ff != '0 && req_time_value > head_ff) begin
                        st_in = ST_NOT_READY;
                     end else begin
                        now_in = req_time_value;
                     end
                  end
                  CMD_POP_DUE: begin
                     if (count_ff != '0 && head_ff == now_ff) begin
                        state_in = S_POP_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     now_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIND_RD: begin
            rd_addr = idx_ff[SLOT_W-1:0];
            if (idx_ff > {1'b0, count_ff}) begin
               state_in = S_DONE;
               if (cmd_ff == CMD_SCHEDULE) begin
                  if ({1'b0, count_ff} >= DEPTH_W) begin
                     st_in = ST_FULL;
                  end else begin
                     count_in = count_ff + SLOT_W'(1);
                     hole_in  = count_ff + SLOT_W'(1);
                     state_in = S_UP_RD;
                  end
               end
            end else begin
               state_in = S_FIND_CK;
            end
         end
         S_FIND_CK: begin
            if (rd_id == eid_ff) begin
               hole_in = idx_ff[SLOT_W-1:0];
               if (cmd_ff == CMD_SCHEDULE) begin
                  state_in = S_REF_RD;
               end else begin
                  last_in  = count_ff;
                  count_in = count_ff - SLOT_W'(1);
                  state_in = (idx_ff[SLOT_W-1:0] < count_ff) ? S_LAST_RD : S_DONE;
               end
            end else begin
               idx_in   = idx_ff + (SLOT_W + 1)'(1);
               state_in = S_FIND_RD;
            end
         end
         S_POP_RD: begin
            rd_addr  = ROOT;
            state_in = S_POP_CK;
         end
         S_POP_CK: begin
            pop_in   = 1'b1;
            pid_in   = rd_id;
            pval_in  = rd_data[VALUE_W-1:0];
            last_in  = count_ff;
            count_in = count_ff - SLOT_W'(1);
            hole_in  = ROOT;
            state_in = (count_ff == ROOT) ? S_DONE : S_LAST_RD;
         end
         S_LAST_RD: begin
            rd_addr  = last_ff;
            state_in = S_LAST_CK;
         end
         S_LAST_CK: begin
            eid_in   = rd_id;
            etime_in = rd_time;
            eval_in  = rd_data[VALUE_W-1:0];
            state_in = (cmd_ff == CMD_POP_DUE) ? S_DN_RD : S_REF_RD;
         end
         S_REF_RD: begin
            rd_addr = hole_ff >> 1;
            if (hole_ff == ROOT) begin
               state_in = S_DN_RD;
            end else begin
               state_in = S_REF_CK;
            end
         end
         S_REF_CK: begin
            state_in = (rd_time < etime_ff) ? S_DN_RD : S_UP_RD;
         end
         S_UP_RD: begin
            rd_addr = hole_ff >> 1;
            if (hole_ff > ROOT) begin
               state_in = S_UP_CK;
            end else begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_UP_CK: begin
            wr_en = 1'b1;
            if (etime_ff < rd_time) begin
               wr_data  = rd_data;
               hole_in  = hole_ff >> 1;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DN_RD: begin
            rd_addr = child[SLOT_W-1:0];
            if (child > {1'b0, count_ff}) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_DN_LCK;
            end
         end
         S_DN_LCK: begin
            rd_addr = child_r[SLOT_W-1:0];
            lent_in = rd_data;
            lidx_in = child[SLOT_W-1:0];
            if (child_r <= {1'b0, count_ff}) begin
               state_in = S_DN_RCK;
            end else begin
               wr_en = 1'b1;
               if (etime_ff < rd_time) begin
                  state_in = S_DONE;
               end else begin
                  wr_data  = rd_data;
                  hole_in  = child[SLOT_W-1:0];
                  state_in = S_DN_RD;
               end
            end
         end
         S_DN_RCK: begin
            wr_en = 1'b1;
            if (rd_time < l_time) begin
               if (etime_ff < rd_time) begin
                  state_in = S_DONE;
               end else begin
                  wr_data  = rd_data;
                  hole_in  = child_r[SLOT_W-1:0];
                  state_in = S_DN_RD;
               end
            end else begin
               if (etime_ff < l_time) begin
                  state_in = S_DONE;
               end else begin
                  wr_data  = lent_ff;
                  hole_in  = lidx_ff;
                  state_in = S_DN_RD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_popped        = o_popped_ff;
   assign rsp_popped_id     = o_pid_ff;
   assign rsp_popped_value  = o_pval_ff;
   assign rsp_next_time     = o_next_ff;
   assign rsp_pending_count = o_count_ff;
   assign rsp_model_time    = o_now_ff;

`ifndef SYNTHESIS
   // The heap never holds more entries than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= DEPTH_W)
      else $error("pending count exceeds queue depth");

   // Slot zero is never written, and no write lands beyond the filled part.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr != '0 && wr_addr <= count_ff))
      else $error("heap write outside the filled slots");

   // While idle with no request offered, the heap size holds.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_valid) |=> $stable(count_ff))
      else $error("pending count changed without a request");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/tehs_heap_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heap entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tehs_heap_ram #(
   parameter int DEPTH  = 2049,
   parameter int ADDR_W = 12,
   parameter int DATA_W = 144
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
